/* design/assert_macros.svh */
// assertion macros used by the rtl top level
// clocked on aclk, disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rcr_pkg.sv */
// shared types and constants for the rc reflectance array reader
// no dependencies
`default_nettype none

package rcr_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int TIME_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int LEVEL_W        = 8;
    localparam int PATTERN_W      = 8;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] CUTOFF_RST        = 16'd1000;
    localparam logic [CFG_W-1:0] CHARGE_TICKS_RST  = 16'd250;
    localparam logic [CFG_W-1:0] MEASURE_LIMIT_RST = 16'd65535;

    typedef struct packed {
        logic [CFG_W-1:0] cutoff;
        logic [CFG_W-1:0] charge_ticks;
        logic [CFG_W-1:0] measure_limit;
    } cfg_t;

    typedef struct packed {
        logic                 drive_high;
        logic                 measuring;
        logic                 pattern_valid;
        logic [PATTERN_W-1:0] line_pattern;
        logic                 timed_out;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_CHARGE  = 3'b010,
        PH_MEASURE = 3'b100
    } phase_t;

endpackage

`default_nettype wire

/* design/rcr_cfg_regs.sv */
// configuration registers: cutoff, charge_ticks, measure_limit
// depends on rcr_pkg
`default_nettype none

module rcr_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [rcr_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [rcr_pkg::CFG_W-1:0]     wr_data,
    output rcr_pkg::cfg_t                     cfg
);

    rcr_pkg::cfg_t cfg_reg;
    rcr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                rcr_pkg::CFG_CUTOFF:        cfg_next.cutoff        = wr_data;
                rcr_pkg::CFG_CHARGE_TICKS:  cfg_next.charge_ticks  = wr_data;
                rcr_pkg::CFG_MEASURE_LIMIT: cfg_next.measure_limit = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff        <= rcr_pkg::CUTOFF_RST;
            cfg_reg.charge_ticks  <= rcr_pkg::CHARGE_TICKS_RST;
            cfg_reg.measure_limit <= rcr_pkg::MEASURE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/rcr_tick_engine.sv */
// per-tick sequencer: charge phase, parallel discharge capture, pattern build
// depends on rcr_pkg; state advances only on step_en
`default_nettype none

module rcr_tick_engine #(
    parameter int CHANNELS   = rcr_pkg::CHANNELS_DEF,
    parameter int TIME_WIDTH = rcr_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step_en,
    input  wire logic                        start_req,
    input  wire logic [rcr_pkg::LEVEL_W-1:0] sensor_levels,
    input  rcr_pkg::cfg_t                    cfg,
    output rcr_pkg::result_t                 result
);

    localparam int CMP_W = (TIME_WIDTH > rcr_pkg::CFG_W) ? TIME_WIDTH : rcr_pkg::CFG_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    rcr_pkg::phase_t                phase_reg, phase_next;
    logic [rcr_pkg::CFG_W-1:0]      tick_reg, tick_next;
    logic [CHANNELS-1:0]            mask_reg, mask_next;
    logic [TIME_WIDTH-1:0]          time_reg  [CHANNELS];
    logic [TIME_WIDTH-1:0]          time_next [CHANNELS];

    logic [rcr_pkg::CFG_W-1:0]      count_inc;
    logic [CMP_W-1:0]               count_w;
    logic [TIME_WIDTH-1:0]          count_t;
    logic [CHANNELS+rcr_pkg::LEVEL_W-1:0] levels_wide;
    logic [CHANNELS-1:0]            low_vec;
    logic [CHANNELS-1:0]            cap_now;
    logic [CHANNELS-1:0]            mask_new;
    logic                           all_done;
    logic                           finish;
    logic                           tmo;
    logic [TIME_WIDTH-1:0]          eff_time [CHANNELS];
    logic [CHANNELS-1:0]            pat_full;
    logic [CHANNELS+rcr_pkg::PATTERN_W-1:0] pat_wide;

    // channels above the pin width read as discharged
    assign levels_wide = {{CHANNELS{1'b0}}, sensor_levels};
    assign low_vec     = ~levels_wide[CHANNELS-1:0];
    assign cap_now     = low_vec & ~mask_reg;
    assign mask_new    = mask_reg | cap_now;
    assign all_done    = &mask_new;
    assign count_inc   = tick_reg + rcr_pkg::CFG_W'(1);
    assign count_w     = CMP_W'(tick_reg);
    assign count_t     = count_w[TIME_WIDTH-1:0];

    // times as they stand after this tick, uncaptured ones at full scale
    always_comb begin
        for (int n = 0; n < CHANNELS; n++) begin
            if (cap_now[n]) begin
                eff_time[n] = count_t;
            end else if (mask_reg[n]) begin
                eff_time[n] = time_reg[n];
            end else begin
                eff_time[n] = TIME_MAX;
            end
            pat_full[n] = CMP_W'(eff_time[n]) > CMP_W'(cfg.cutoff);
        end
    end

    assign pat_wide = {{rcr_pkg::PATTERN_W{1'b0}}, pat_full};

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        mask_next  = mask_reg;
        time_next  = time_reg;
        finish     = 1'b0;
        tmo        = 1'b0;
        case (phase_reg)
            rcr_pkg::PH_IDLE: begin
                if (start_req) begin
                    tick_next  = '0;
                    mask_next  = '0;
                    for (int n = 0; n < CHANNELS; n++) begin
                        time_next[n] = '0;
                    end
                    phase_next = rcr_pkg::PH_CHARGE;
                end
            end
            rcr_pkg::PH_CHARGE: begin
                tick_next = count_inc;
                if (count_inc >= cfg.charge_ticks) begin
                    tick_next  = '0;
                    phase_next = rcr_pkg::PH_MEASURE;
                end
            end
            rcr_pkg::PH_MEASURE: begin
                mask_next = mask_new;
                for (int n = 0; n < CHANNELS; n++) begin
                    if (cap_now[n]) begin
                        time_next[n] = count_t;
                    end
                end
                if (all_done) begin
                    finish = 1'b1;
                end else begin
                    tick_next = count_inc;
                    if (count_inc >= cfg.measure_limit) begin
                        finish = 1'b1;
                        tmo    = 1'b1;
                    end
                end
                if (finish) begin
                    phase_next = rcr_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = rcr_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rcr_pkg::PH_IDLE;
            tick_reg  <= '0;
            mask_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            time_reg <= time_next;
        end
    end

    always_comb begin
        result.drive_high    = (phase_next == rcr_pkg::PH_CHARGE);
        result.measuring     = (phase_next == rcr_pkg::PH_MEASURE);
        result.pattern_valid = finish;
        result.line_pattern  = finish ? pat_wide[rcr_pkg::PATTERN_W-1:0] : '0;
        result.timed_out     = tmo;
    end

endmodule

`default_nettype wire

/* design/rc_reflectance_array_reader_top.sv */
// top level of the rc reflectance array reader: input register, tick engine,
// result register and configuration port; depends on rcr_pkg, rcr_cfg_regs,
// rcr_tick_engine and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

// One transfer on the s_ channel is one timer tick with the sampled pin levels
// and a start request; each one yields exactly one result transfer on the m_
// channel showing the phase after that tick and, on the finishing tick, the
// line pattern and timeout flag. A new tick is taken every clock cycle; a tick
// passes through an input register and then the result register before its
// result is offered. The result register with its ready is the only thing that
// can slow the flow. Configuration writes are taken every cycle on the cfg_
// channel and belong only between reading cycles.
module rc_reflectance_array_reader_top #(
    parameter int CHANNELS   = rcr_pkg::CHANNELS_DEF,
    parameter int TIME_WIDTH = rcr_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic                           s_start_req,
    input  wire logic [rcr_pkg::LEVEL_W-1:0]    s_sensor_levels,

    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic                           m_drive_high,
    output      logic                           m_measuring,
    output      logic                           m_pattern_valid,
    output      logic [rcr_pkg::PATTERN_W-1:0]  m_line_pattern,
    output      logic                           m_timed_out,

    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rcr_pkg::CFG_W-1:0]      cfg_data
);

    rcr_pkg::cfg_t                  cfg;
    rcr_pkg::result_t               result;
    rcr_pkg::result_t               out_reg;

    logic                           in_valid_reg, in_valid_next;
    logic                           in_start_reg;
    logic [rcr_pkg::LEVEL_W-1:0]    in_levels_reg;
    logic                           m_valid_reg;
    logic                           advance;
    logic                           in_xfer;
    logic                           step_en;

    assign cfg_ready = 1'b1;

    rcr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipeline flow control
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;
    assign step_en = in_valid_reg && advance;

    always_comb begin
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_start_reg  <= s_start_req;
            in_levels_reg <= s_sensor_levels;
        end
        if (step_en) begin
            out_reg <= result;
        end
    end

    rcr_tick_engine #(
        .CHANNELS   (CHANNELS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .start_req     (in_start_reg),
        .sensor_levels (in_levels_reg),
        .cfg           (cfg),
        .result        (result)
    );

    assign m_valid         = m_valid_reg;
    assign m_drive_high    = out_reg.drive_high;
    assign m_measuring     = out_reg.measuring;
    assign m_pattern_valid = out_reg.pattern_valid;
    assign m_line_pattern  = out_reg.line_pattern;
    assign m_timed_out     = out_reg.timed_out;

    `RCR_ASSERT_NOW(a_finish_idle, m_valid && m_pattern_valid, !m_drive_high && !m_measuring, "finished pattern while not idle")
    `RCR_ASSERT_NOW(a_tmo_valid, m_valid && m_timed_out, m_pattern_valid, "timeout without finished pattern")
    `RCR_ASSERT_NOW(a_pattern_zero, m_valid && !m_pattern_valid, m_line_pattern == '0, "pattern shown outside finishing tick")
    `RCR_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg, "stalled tick dropped")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for rc_reflectance_array_reader_top: random and directed
// pin-sample ticks, a tick-by-tick predictor of the reading sequence and a scoreboard
// depends on rcr_pkg and the rc_reflectance_array_reader_top rtl
module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;

    class reading_scoreboard;
        logic [rcr_pkg::CFG_W-1:0] cutoff;
        logic [rcr_pkg::CFG_W-1:0] charge_ticks;
        logic [rcr_pkg::CFG_W-1:0] measure_limit;
        rcr_pkg::phase_t           phase_now;
        int unsigned               tick_count;
        logic [7:0]                captured;
        logic [15:0]               discharge[8];
        rcr_pkg::result_t          pending_readings[$];
        int                        errors;
        int                        ticks_seen;
        int                        results_seen;
        int                        patterns_seen;
        int                        timeouts_seen;

        function new();
            cutoff        = rcr_pkg::CUTOFF_RST;
            charge_ticks  = rcr_pkg::CHARGE_TICKS_RST;
            measure_limit = rcr_pkg::MEASURE_LIMIT_RST;
            phase_now     = rcr_pkg::PH_IDLE;
            tick_count    = 0;
            captured      = '0;
            foreach (discharge[n]) discharge[n] = '0;
            errors        = 0;
            ticks_seen    = 0;
            results_seen  = 0;
            patterns_seen = 0;
            timeouts_seen = 0;
        endfunction

        function void write_reg(logic [rcr_pkg::CFG_IDX_W-1:0] idx,
                                logic [rcr_pkg::CFG_W-1:0] val);
            case (idx)
                rcr_pkg::CFG_CUTOFF:        cutoff = val;
                rcr_pkg::CFG_CHARGE_TICKS:  charge_ticks = val;
                rcr_pkg::CFG_MEASURE_LIMIT: measure_limit = val;
                default: ;
            endcase
        endfunction

        // one accepted tick, one predicted result
        function void note_tick(bit start, logic [rcr_pkg::LEVEL_W-1:0] levels);
            rcr_pkg::result_t r;
            r = '0;
            ticks_seen++;
            case (phase_now)
                rcr_pkg::PH_IDLE: begin
                    if (start) begin
                        tick_count = 0;
                        captured   = '0;
                        foreach (discharge[n]) discharge[n] = '0;
                        phase_now  = rcr_pkg::PH_CHARGE;
                    end
                end
                rcr_pkg::PH_CHARGE: begin
                    tick_count = (tick_count + 1) & 32'hFFFF;
                    if (tick_count >= charge_ticks) begin
                        tick_count = 0;
                        phase_now  = rcr_pkg::PH_MEASURE;
                    end
                end
                rcr_pkg::PH_MEASURE: begin
                    for (int n = 0; n < 8; n++) begin
                        if (!levels[n] && !captured[n]) begin
                            captured[n]  = 1'b1;
                            discharge[n] = tick_count[15:0];
                        end
                    end
                    if (&captured) begin
                        r.pattern_valid = 1'b1;
                    end else begin
                        tick_count = (tick_count + 1) & 32'hFFFFF;
                        if (tick_count >= measure_limit) begin
                            for (int n = 0; n < 8; n++)
                                if (!captured[n]) discharge[n] = 16'hFFFF;
                            r.pattern_valid = 1'b1;
                            r.timed_out     = 1'b1;
                        end
                    end
                    if (r.pattern_valid) begin
                        for (int n = 0; n < 8; n++)
                            r.line_pattern[n] = (discharge[n] > cutoff);
                        phase_now = rcr_pkg::PH_IDLE;
                    end
                end
                default: phase_now = rcr_pkg::PH_IDLE;
            endcase
            r.drive_high = (phase_now == rcr_pkg::PH_CHARGE);
            r.measuring  = (phase_now == rcr_pkg::PH_MEASURE);
            pending_readings.push_back(r);
        endfunction

        function void cmp(string fname, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0h, got %0h", fname, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(rcr_pkg::result_t got);
            rcr_pkg::result_t want;
            results_seen++;
            if (pending_readings.size() == 0) begin
                $error("result transfer with no tick outstanding");
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            if (want.pattern_valid) patterns_seen++;
            if (want.timed_out) timeouts_seen++;
            cmp("drive_high", 16'(want.drive_high), 16'(got.drive_high));
            cmp("measuring", 16'(want.measuring), 16'(got.measuring));
            cmp("pattern_valid", 16'(want.pattern_valid), 16'(got.pattern_valid));
            cmp("line_pattern", 16'(want.line_pattern), 16'(got.line_pattern));
            cmp("timed_out", 16'(want.timed_out), 16'(got.timed_out));
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_start_req;
    logic [rcr_pkg::LEVEL_W-1:0]   s_sensor_levels;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_drive_high;
    logic                          m_measuring;
    logic                          m_pattern_valid;
    logic [rcr_pkg::PATTERN_W-1:0] m_line_pattern;
    logic                          m_timed_out;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rcr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcr_pkg::CFG_W-1:0]     cfg_data;

    reading_scoreboard sb;

    bit   gaps_on;
    int   burst_left;
    bit   hold_req;
    int   cycle_count;

    // stimulus sequence state: which channels are still charged
    logic [7:0] seq_charged;
    logic [7:0] seq_stuck;
    int         seq_rate;
    int         seq_cap;
    int         seq_ticks;
    bit         seq_timeout;

    rc_reflectance_array_reader_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_sensor_levels (s_sensor_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_high    (m_drive_high),
        .m_measuring     (m_measuring),
        .m_pattern_valid (m_pattern_valid),
        .m_line_pattern  (m_line_pattern),
        .m_timed_out     (m_timed_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL rc_reflectance_array_reader_top");
        $finish;
    end

    // result side: stalls on a pattern of its own, one long holdoff on request
    initial begin
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left  = 0;
        m_ready    = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(10, 80);
                end
                mode_left--;
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_drive_high, m_measuring, m_pattern_valid,
                              m_line_pattern, m_timed_out});
    end

    task automatic send_tick(bit start, logic [rcr_pkg::LEVEL_W-1:0] levels);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        s_valid         <= 1'b1;
        s_start_req     <= start;
        s_sensor_levels <= levels;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(start, levels);
    endtask

    task automatic write_cfg(logic [rcr_pkg::CFG_IDX_W-1:0] idx,
                             logic [rcr_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic write_all(logic [rcr_pkg::CFG_W-1:0] cut, logic [rcr_pkg::CFG_W-1:0] chg,
                             logic [rcr_pkg::CFG_W-1:0] lim);
        write_cfg(rcr_pkg::CFG_CUTOFF, cut);
        write_cfg(rcr_pkg::CFG_CHARGE_TICKS, chg);
        write_cfg(rcr_pkg::CFG_MEASURE_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_readings.size() > 0);
    endtask

    // next tick from the current predicted phase: mostly well-formed discharge runs
    task automatic next_tick(bit allow_start);
        bit         start;
        logic [7:0] levels;
        start  = 1'b0;
        levels = 8'($urandom);
        case (sb.phase_now)
            rcr_pkg::PH_IDLE: begin
                if (allow_start && $urandom_range(0, 9) != 0) begin
                    start       = 1'b1;
                    seq_charged = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hFF;
                    seq_rate    = $urandom_range(2, 12);
                    seq_cap     = $urandom_range(4, 48);
                    seq_timeout = (sb.measure_limit <= 64) && ($urandom_range(0, 3) == 0);
                    seq_stuck   = 8'h01 << $urandom_range(0, 7);
                    seq_ticks   = 0;
                end
            end
            rcr_pkg::PH_CHARGE: start = ($urandom_range(0, 3) == 0);
            default: begin
                for (int n = 0; n < 8; n++)
                    if (seq_charged[n] && $urandom_range(1, seq_rate) == 1)
                        seq_charged[n] = 1'b0;
                seq_ticks++;
                if (seq_timeout)
                    seq_charged |= seq_stuck;
                else if (seq_ticks >= seq_cap || !allow_start)
                    seq_charged = '0;
                levels = seq_charged;
                if ($urandom_range(0, 9) == 0) levels ^= 8'h01 << $urandom_range(0, 7);
                start = ($urandom_range(0, 3) == 0);
            end
        endcase
        send_tick(start, levels);
    endtask

    task automatic run_phase(logic [rcr_pkg::CFG_W-1:0] cut, logic [rcr_pkg::CFG_W-1:0] chg,
                             logic [rcr_pkg::CFG_W-1:0] lim, int n_ticks, bit no_start,
                             bit hold, bit pause_mid);
        int sent;
        sent = 0;
        drain_results();
        write_all(cut, chg, lim);
        gaps_on = hold ? 1'b0 : ($urandom_range(0, 3) != 0);
        if (hold) hold_req = 1'b1;
        while (sent < n_ticks || sb.phase_now != rcr_pkg::PH_IDLE) begin
            next_tick(sent < n_ticks && !no_start);
            sent++;
            if (pause_mid && sent == n_ticks / 2) drain_results();
        end
    endtask

    initial begin
        sb              = new();
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_start_req     = 1'b0;
        s_sensor_levels = '0;
        cfg_valid       = 1'b0;
        cfg_index       = rcr_pkg::CFG_CUTOFF;
        cfg_data        = '0;
        gaps_on         = 1'b1;
        burst_left      = 0;
        hold_req        = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero registers: zero charge acts as one tick, zero limit times out at once
        write_all(16'd0, 16'd0, 16'd0);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'h00);
        send_tick(1'b0, 8'h00);
        send_tick(1'b1, 8'hA5);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'hA5);
        send_tick(1'b1, 8'h00);
        send_tick(1'b0, 8'h00);
        send_tick(1'b0, 8'h00);
        drain_results();
        // full-scale cutoff against timed-out channels
        write_all(16'hFFFF, 16'd1, 16'd3);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'hFF);
        drain_results();
        // staggered capture, start ignored on the finishing tick
        write_all(16'd1, 16'd2, 16'hFFFF);
        send_tick(1'b1, 8'h55);
        send_tick(1'b0, 8'h55);
        send_tick(1'b1, 8'hAA);
        send_tick(1'b0, 8'h0F);
        send_tick(1'b1, 8'h03);
        send_tick(1'b1, 8'h00);

        run_phase(16'd20, 16'hFFFF, 16'd30, 6, 1'b1, 1'b0, 1'b0);
        run_phase(rcr_pkg::CUTOFF_RST, rcr_pkg::CHARGE_TICKS_RST, rcr_pkg::MEASURE_LIMIT_RST,
                  20, 1'b0, 1'b0, 1'b0);
        run_phase(16'd8, 16'd1, 16'd16, 140, 1'b0, 1'b1, 1'b0);
        run_phase(16'd0, 16'd0, 16'd1, 80, 1'b0, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'd3, 16'hFFFF, 80, 1'b0, 1'b0, 1'b0);
        run_phase(16'd30, 16'd5, 16'd40, 140, 1'b0, 1'b0, 1'b1);
        repeat (2)
            run_phase(16'($urandom_range(0, 24)), 16'($urandom_range(0, 6)),
                      16'($urandom_range(1, 32)), 100, 1'b0, 1'b0, 1'b0);
        run_phase(16'd12, 16'd2, 16'hFFFF, 60, 1'b0, 1'b0, 1'b0);

        drain_results();
        repeat (10) @(posedge aclk);
        $display("covered %0d ticks and %0d results: %0d finished readings, %0d timed out",
                 sb.ticks_seen, sb.results_seen, sb.patterns_seen, sb.timeouts_seen);
        $display("register settings included zero and full-scale values, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending_readings.size() == 0)
            $display("PASS rc_reflectance_array_reader_top");
        else
            $display("FAIL rc_reflectance_array_reader_top");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/rcr_pkg.sv
design/rcr_cfg_regs.sv
design/rcr_tick_engine.sv
design/rc_reflectance_array_reader_top.sv
tb/testbench.sv
